[src/cnv_pkg.sv]
package cnv_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int INDEX_BITS = 6;
   localparam int NUM_TAPS_BITS = 7;
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS = 40;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   typedef enum logic {
      OP_LOAD,
      OP_SAMPLE
   } cnv_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SHIFT,
      ST_MAC,
      ST_DRAIN
   } cnv_state_type;

   typedef struct packed {
      logic                          cmd;
      logic signed [SAMPLE_BITS-1:0] sample_re;
      logic signed [SAMPLE_BITS-1:0] sample_im;
      logic                          last_sample;
      logic [INDEX_BITS-1:0]         coef_index;
      logic signed [COEF_BITS-1:0]   coef_re;
      logic signed [COEF_BITS-1:0]   coef_im;
   } cnv_req_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] out_re;
      logic signed [ACC_BITS-1:0] out_im;
      logic                       out_last;
   } cnv_rsp_type;

   typedef struct packed {
      cnv_op_type                    op;
      logic                          last;
      logic [INDEX_BITS-1:0]         idx;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } cnv_entry_type;

   typedef struct packed {
      logic          valid;
      cnv_entry_type entry;
   } cnv_queue_type;

endpackage

[src/complex_linear_convolution.sv]
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    cnv_req_type: load coefficient or sample
// rsp      out  rsp_valid/rsp_ready    cnv_rsp_type: 40-bit complex sum, last flag
// csr      in   csr_valid/csr_ready    num_taps, 7 bits, ready always high
//
// A sample goes through the shared complex multiply-accumulate: one history
// write, one tap read per cycle, the RAM read and product registers, one transfer.
// A last sample adds taps-1 tail outputs; a load only writes the coefficient RAM.
// After reset a pass zeroes all MAX_TAPS coefficient RAM words with req_ready low.
// A two-entry queue and the output register let each side stall on its own.
module complex_linear_convolution #(
   parameter int MAX_TAPS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cnv_pkg::cnv_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cnv_pkg::cnv_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cnv_pkg::NUM_TAPS_BITS-1:0]    csr_data
);

   localparam int CNT_BITS = $clog2(MAX_TAPS + 1);

   logic [cnv_pkg::NUM_TAPS_BITS-1:0] num_taps_ff;
   logic [cnv_pkg::NUM_TAPS_BITS-1:0] num_taps_in;
   logic [CNT_BITS-1:0] taps;
   cnv_pkg::cnv_queue_type queue;
   logic pop;
   logic clearing;

   assign csr_ready = 1'b1;
   assign num_taps_in = (csr_valid && csr_ready) ? csr_data : num_taps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff <= cnv_pkg::NUM_TAPS_BITS'(1);
      end else begin
         num_taps_ff <= num_taps_in;
      end
   end

   always_comb begin
      if (num_taps_ff == '0) begin
         taps = CNT_BITS'(1);
      end else if (32'(num_taps_ff) > MAX_TAPS) begin
         taps = CNT_BITS'(MAX_TAPS);
      end else begin
         taps = CNT_BITS'(num_taps_ff);
      end
   end

   cnv_front #(
      .MAX_TAPS(MAX_TAPS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .clearing(clearing),
      .queue(queue),
      .pop(pop)
   );

   cnv_back #(
      .MAX_TAPS(MAX_TAPS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue(queue),
      .pop(pop),
      .clearing(clearing),
      .taps(taps),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue.valid)
      else $error("pop from empty queue");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      (queue.valid && queue.entry.op == cnv_pkg::OP_LOAD) |-> (32'(queue.entry.idx) < MAX_TAPS))
      else $error("out of range load reached the back end");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready && !pop)
      else $error("transfer taken during coefficient clear");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && clearing)
      else $error("reset did not restart the clear pass");

endmodule

[src/cnv_ram.sv]
module cnv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cnv_front.sv]
module cnv_front #(
   parameter int MAX_TAPS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cnv_pkg::cnv_req_type  req_data,
   input  logic                  clearing,
   output cnv_pkg::cnv_queue_type queue,
   input  logic                  pop
);

   cnv_pkg::cnv_entry_type q_ff [cnv_pkg::QUEUE_DEPTH];
   logic [cnv_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cnv_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cnv_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   cnv_pkg::cnv_entry_type entry;
   logic keep;
   logic push;

   always_comb begin
      entry.op = req_data.cmd ? cnv_pkg::OP_SAMPLE : cnv_pkg::OP_LOAD;
      entry.last = req_data.last_sample;
      entry.idx = req_data.coef_index;
      entry.re = req_data.cmd ? req_data.sample_re : req_data.coef_re;
      entry.im = req_data.cmd ? req_data.sample_im : req_data.coef_im;
   end

   // drop loads that fall outside the coefficient store
   assign keep = req_data.cmd || (32'(req_data.coef_index) < MAX_TAPS);
   assign req_ready = !clearing && (count_ff != cnv_pkg::QUEUE_CNT_BITS'(cnv_pkg::QUEUE_DEPTH));
   assign push = req_valid && req_ready && keep;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + {{(cnv_pkg::QUEUE_CNT_BITS-1){1'b0}}, push}
                          - {{(cnv_pkg::QUEUE_CNT_BITS-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign queue.valid = (count_ff != '0);
   assign queue.entry = q_ff[rd_ptr_ff];

endmodule

[src/cnv_back.sv]
module cnv_back #(
   parameter int MAX_TAPS = 64,
   localparam int ADDR_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
   localparam int CNT_BITS = $clog2(MAX_TAPS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cnv_pkg::cnv_queue_type queue,
   output logic                   pop,
   output logic                   clearing,
   input  logic [CNT_BITS-1:0]    taps,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cnv_pkg::cnv_rsp_type   rsp_data
);

   localparam int SW = cnv_pkg::SAMPLE_BITS;
   localparam int CW = cnv_pkg::COEF_BITS;
   localparam int AW = cnv_pkg::ACC_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_TAPS - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(MAX_TAPS);

   cnv_pkg::cnv_state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic [ADDR_BITS-1:0] wptr_ff, wptr_in;
   logic [CNT_BITS-1:0]  hcount_ff, hcount_in;
   logic [ADDR_BITS-1:0] rd_n_ff, rd_n_in;
   logic [ADDR_BITS-1:0] raddr_ff, raddr_in;
   logic [CNT_BITS-1:0]  tail_ff, tail_in;
   logic                 last_ff, last_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_hv_ff, s1_hv_in;
   logic                 s2_valid_ff;
   logic signed [AW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [AW-1:0] acc_re_ff, acc_im_ff;
   logic                 acc_clear;
   logic                 rsp_valid_ff, rsp_valid_in;
   cnv_pkg::cnv_rsp_type rsp_ff, rsp_in;

   logic                 tap_wr_en;
   logic [ADDR_BITS-1:0] tap_wr_addr;
   logic [2*CW-1:0]      tap_wr_data;
   logic [2*CW-1:0]      tap_rd_data;
   logic                 hist_wr_en;
   logic [2*SW-1:0]      hist_wr_data;
   logic [2*SW-1:0]      hist_rd_data;

   logic [ADDR_BITS-1:0] wptr_next;
   logic                 shift;
   logic                 issue_end;
   logic                 pipe_busy;
   logic                 emit;

   logic signed [SW-1:0] h_re, h_im;
   logic signed [CW-1:0] c_re, c_im;
   logic signed [cnv_pkg::PROD_BITS-1:0] m_rr, m_ii, m_ri, m_ir;

   assign wptr_next = (wptr_ff == LAST_ADDR) ? '0 : wptr_ff + 1'b1;
   assign issue_end = (CNT_BITS'(rd_n_ff) == taps - 1'b1);
   assign pipe_busy = s1_valid_ff || s2_valid_ff;
   assign emit = (state_ff == cnv_pkg::ST_DRAIN) && !pipe_busy
                 && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cnv_pkg::ST_CLEAR: begin
            if (clr_idx_ff == LAST_ADDR) begin
               state_in = cnv_pkg::ST_IDLE;
            end
         end
         cnv_pkg::ST_IDLE: begin
            if (queue.valid && queue.entry.op == cnv_pkg::OP_SAMPLE) begin
               state_in = cnv_pkg::ST_MAC;
            end
         end
         cnv_pkg::ST_SHIFT: begin
            state_in = cnv_pkg::ST_MAC;
         end
         cnv_pkg::ST_MAC: begin
            if (issue_end) begin
               state_in = cnv_pkg::ST_DRAIN;
            end
         end
         cnv_pkg::ST_DRAIN: begin
            if (emit) begin
               state_in = (tail_ff != '0) ? cnv_pkg::ST_SHIFT : cnv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cnv_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop = 1'b0;
      clearing = 1'b0;
      clr_idx_in = clr_idx_ff;
      wptr_in = wptr_ff;
      hcount_in = hcount_ff;
      rd_n_in = rd_n_ff;
      raddr_in = raddr_ff;
      tail_in = tail_ff;
      last_in = last_ff;
      s1_valid_in = 1'b0;
      s1_hv_in = 1'b0;
      acc_clear = 1'b0;
      shift = 1'b0;
      tap_wr_en = 1'b0;
      tap_wr_addr = clr_idx_ff;
      tap_wr_data = '0;
      hist_wr_data = '0;
      unique case (state_ff)
         cnv_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            tap_wr_en = 1'b1;
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         cnv_pkg::ST_IDLE: begin
            if (queue.valid) begin
               pop = 1'b1;
               if (queue.entry.op == cnv_pkg::OP_LOAD) begin
                  tap_wr_en = 1'b1;
                  tap_wr_addr = ADDR_BITS'(queue.entry.idx);
                  tap_wr_data = {queue.entry.re, queue.entry.im};
               end else begin
                  shift = 1'b1;
                  hist_wr_data = {queue.entry.re, queue.entry.im};
                  last_in = queue.entry.last;
                  tail_in = queue.entry.last ? taps - 1'b1 : '0;
               end
            end
         end
         cnv_pkg::ST_SHIFT: begin
            shift = 1'b1;
         end
         cnv_pkg::ST_MAC: begin
            s1_valid_in = 1'b1;
            s1_hv_in = (CNT_BITS'(rd_n_ff) < hcount_ff);
            rd_n_in = rd_n_ff + 1'b1;
            raddr_in = (raddr_ff == '0) ? LAST_ADDR : raddr_ff - 1'b1;
         end
         cnv_pkg::ST_DRAIN: begin
            if (emit) begin
               if (tail_ff != '0) begin
                  tail_in = tail_ff - 1'b1;
               end else if (last_ff) begin
                  hcount_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
      if (shift) begin
         wptr_in = wptr_next;
         hcount_in = (hcount_ff == FULL_CNT) ? hcount_ff : hcount_ff + 1'b1;
         raddr_in = wptr_next;
         rd_n_in = '0;
         acc_clear = 1'b1;
      end
   end

   assign hist_wr_en = shift;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.out_re = acc_re_ff;
         rsp_in.out_im = acc_im_ff;
         rsp_in.out_last = last_ff && (tail_ff == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   cnv_ram #(
      .WIDTH(2*CW),
      .DEPTH(MAX_TAPS)
   ) u_tap_ram (
      .clock(clock),
      .wr_en(tap_wr_en),
      .wr_addr(tap_wr_addr),
      .wr_data(tap_wr_data),
      .rd_addr(rd_n_ff),
      .rd_data(tap_rd_data)
   );

   cnv_ram #(
      .WIDTH(2*SW),
      .DEPTH(MAX_TAPS)
   ) u_hist_ram (
      .clock(clock),
      .wr_en(hist_wr_en),
      .wr_addr(wptr_next),
      .wr_data(hist_wr_data),
      .rd_addr(raddr_ff),
      .rd_data(hist_rd_data)
   );

   assign h_re = s1_hv_ff ? hist_rd_data[2*SW-1:SW] : '0;
   assign h_im = s1_hv_ff ? hist_rd_data[SW-1:0] : '0;
   assign c_re = tap_rd_data[2*CW-1:CW];
   assign c_im = tap_rd_data[CW-1:0];
   assign m_rr = h_re * c_re;
   assign m_ii = h_im * c_im;
   assign m_ri = h_re * c_im;
   assign m_ir = h_im * c_re;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cnv_pkg::ST_CLEAR;
         clr_idx_ff <= '0;
         wptr_ff <= '0;
         hcount_ff <= '0;
         tail_ff <= '0;
         last_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         wptr_ff <= wptr_in;
         hcount_ff <= hcount_in;
         tail_ff <= tail_in;
         last_ff <= last_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_n_ff <= rd_n_in;
      raddr_ff <= raddr_in;
      s1_hv_ff <= s1_hv_in;
      p_rr_ff <= AW'(m_rr);
      p_ii_ff <= AW'(m_ii);
      p_ri_ff <= AW'(m_ri);
      p_ir_ff <= AW'(m_ir);
      rsp_ff <= rsp_in;
      if (acc_clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_re_ff <= acc_re_ff + p_rr_ff - p_ii_ff;
         acc_im_ff <= acc_im_ff + p_ri_ff + p_ir_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
